// File: rtl/core/nnld_pkg.sv
// ============================================================================
// nnld_pkg
// Shared widths, constants and types of the nearest-neighbor luma downscaler.
// ============================================================================
`default_nettype none

package nnld_pkg;

    // Largest frame dimension that the counters are sized for.
    localparam int MAX_DIMENSION = 4096;

    // Width of each size register.
    localparam int CFG_W = 13;

    // Configuration port widths.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Size register indexes; the byte address is four times the index.
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

    // Item field widths.
    localparam int LUMA_W = 8;

    // Offset that turns an unsigned luma byte into a signed sample.
    localparam logic [LUMA_W-1:0] LUMA_OFFSET = 8'd128;

    // Size registers as seen by the datapath.
    typedef struct packed {
        logic [CFG_W-1:0] source_width;
        logic [CFG_W-1:0] source_height;
        logic [CFG_W-1:0] target_width;
        logic [CFG_W-1:0] target_height;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic signed [LUMA_W-1:0] sample;
        logic                     line_end;
        logic                     frame_end;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/nnld_cfg.sv
// ============================================================================
// nnld_cfg
// APB register file that holds the source and target frame sizes.
// ============================================================================
`default_nettype none

module nnld_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [nnld_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [nnld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [nnld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output nnld_pkg::cfg_t                        cfg
);

    localparam int CFG_W = nnld_pkg::CFG_W;

    nnld_pkg::cfg_t    cfg_reg;
    nnld_pkg::cfg_t    cfg_next;
    logic              wr_en;
    logic [1:0]        reg_index;
    logic [CFG_W-1:0]  wr_value;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign wr_value  = pwdata[CFG_W-1:0];

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                nnld_pkg::REG_SOURCE_WIDTH:  cfg_next.source_width  = wr_value;
                nnld_pkg::REG_SOURCE_HEIGHT: cfg_next.source_height = wr_value;
                nnld_pkg::REG_TARGET_WIDTH:  cfg_next.target_width  = wr_value;
                nnld_pkg::REG_TARGET_HEIGHT: cfg_next.target_height = wr_value;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_index)
            nnld_pkg::REG_SOURCE_WIDTH:
                prdata = nnld_pkg::APB_DATA_W'(cfg_reg.source_width);
            nnld_pkg::REG_SOURCE_HEIGHT:
                prdata = nnld_pkg::APB_DATA_W'(cfg_reg.source_height);
            nnld_pkg::REG_TARGET_WIDTH:
                prdata = nnld_pkg::APB_DATA_W'(cfg_reg.target_width);
            nnld_pkg::REG_TARGET_HEIGHT:
                prdata = nnld_pkg::APB_DATA_W'(cfg_reg.target_height);
            default:
                prdata = '0;
        endcase
    end

    // Registers come out of reset at a 640x480 to 96x96 setup.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= CFG_W'(640);
            cfg_reg.source_height <= CFG_W'(480);
            cfg_reg.target_width  <= CFG_W'(96);
            cfg_reg.target_height <= CFG_W'(96);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/nnld_sel.sv
// ============================================================================
// nnld_sel
// Position counters and nearest-neighbor pick logic, one item per cycle in which fire is set.
// ============================================================================
`default_nettype none

module nnld_sel
#(
    parameter int MAX_DIMENSION = nnld_pkg::MAX_DIMENSION
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [nnld_pkg::LUMA_W-1:0]   luma,
    input  wire logic                          frame_start,
    input  wire nnld_pkg::cfg_t                cfg,
    output logic                               emit,
    output nnld_pkg::result_t                  result
);

    localparam int     DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam longint MAX_SQ = longint'(MAX_DIMENSION) * longint'(MAX_DIMENSION);
    localparam int     SUM_W  = $clog2(MAX_SQ);

    // Clamp a size register to the range 1 to MAX_DIMENSION.
    function automatic logic [DIM_W-1:0] clamp_size(input logic [nnld_pkg::CFG_W-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            if (w == 32'd0)
                w = 32'd1;
            else if (w > 32'(MAX_DIMENSION))
                w = 32'(MAX_DIMENSION);
            return DIM_W'(w);
        end
    endfunction

    logic [DIM_W-1:0] sw, sh, dw, dh;

    logic [DIM_W-1:0] source_column_reg, source_column_next;
    logic [DIM_W-1:0] source_row_reg,    source_row_next;
    logic [DIM_W-1:0] target_column_reg, target_column_next;
    logic [DIM_W-1:0] target_row_reg,    target_row_next;
    logic [SUM_W-1:0] column_target_sum_reg, column_target_sum_next;
    logic [SUM_W-1:0] column_base_sum_reg,   column_base_sum_next;
    logic [SUM_W-1:0] row_target_sum_reg,    row_target_sum_next;
    logic [SUM_W-1:0] row_base_sum_reg,      row_base_sum_next;

    // State seen by this item, after a possible frame restart.
    logic [DIM_W-1:0] sc, sr, tc, tr;
    logic [SUM_W-1:0] cts, cbs, rts, rbs;

    logic [DIM_W:0]   tc_inc, tr_inc, sc_inc, sr_inc;
    logic             row_pick, col_pick, last_col, last_row, line_wrap;

    assign sw = clamp_size(cfg.source_width);
    assign sh = clamp_size(cfg.source_height);
    assign dw = clamp_size(cfg.target_width);
    assign dh = clamp_size(cfg.target_height);

    // A frame start clears the counters before the pixel is handled.
    always_comb
    begin
        if (frame_start)
        begin
            sc  = '0;
            sr  = '0;
            tc  = '0;
            tr  = '0;
            cts = '0;
            cbs = '0;
            rts = '0;
            rbs = '0;
        end
        else
        begin
            sc  = source_column_reg;
            sr  = source_row_reg;
            tc  = target_column_reg;
            tr  = target_row_reg;
            cts = column_target_sum_reg;
            cbs = column_base_sum_reg;
            rts = row_target_sum_reg;
            rbs = row_base_sum_reg;
        end
    end

    // Pick test: target sum below base sum plus target size.
    assign row_pick = (tr < dh) &&
                      ({1'b0, rts} < ({1'b0, rbs} + (SUM_W + 1)'(dh)));
    assign col_pick = (tc < dw) &&
                      ({1'b0, cts} < ({1'b0, cbs} + (SUM_W + 1)'(dw)));
    assign emit     = row_pick && col_pick;

    assign tc_inc    = {1'b0, tc} + (DIM_W + 1)'(1);
    assign tr_inc    = {1'b0, tr} + (DIM_W + 1)'(1);
    assign sc_inc    = {1'b0, sc} + (DIM_W + 1)'(1);
    assign sr_inc    = {1'b0, sr} + (DIM_W + 1)'(1);
    assign last_col  = tc_inc >= {1'b0, dw};
    assign last_row  = tr_inc >= {1'b0, dh};
    assign line_wrap = sc_inc >= {1'b0, sw};

    // Result fields.
    always_comb
    begin
        result.sample    = $signed(luma - nnld_pkg::LUMA_OFFSET);
        result.line_end  = last_col;
        result.frame_end = last_col && last_row;
    end

    // Counter and accumulator update for one source pixel.
    always_comb
    begin
        source_column_next     = source_column_reg;
        source_row_next        = source_row_reg;
        target_column_next     = target_column_reg;
        target_row_next        = target_row_reg;
        column_target_sum_next = column_target_sum_reg;
        column_base_sum_next   = column_base_sum_reg;
        row_target_sum_next    = row_target_sum_reg;
        row_base_sum_next      = row_base_sum_reg;
        if (fire)
        begin
            source_row_next      = sr;
            target_row_next      = tr;
            row_target_sum_next  = rts;
            row_base_sum_next    = rbs;
            if (line_wrap)
            begin
                // End of a source line: restart columns, step rows, and wrap them at the end of the source frame.
                source_column_next     = '0;
                target_column_next     = '0;
                column_target_sum_next = '0;
                column_base_sum_next   = '0;
                if (row_pick)
                begin
                    if (!last_row)
                        row_target_sum_next = rts + SUM_W'(sh);
                    target_row_next = DIM_W'(tr_inc);
                end
                row_base_sum_next = rbs + SUM_W'(dh);
                source_row_next   = DIM_W'(sr_inc);
                if (sr_inc >= {1'b0, sh})
                begin
                    source_row_next     = '0;
                    target_row_next     = '0;
                    row_target_sum_next = '0;
                    row_base_sum_next   = '0;
                end
            end
            else
            begin
                source_column_next     = DIM_W'(sc_inc);
                column_base_sum_next   = cbs + SUM_W'(dw);
                target_column_next     = tc;
                column_target_sum_next = cts;
                if (emit)
                begin
                    if (!last_col)
                        column_target_sum_next = cts + SUM_W'(sw);
                    target_column_next = DIM_W'(tc_inc);
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_column_reg     <= '0;
            source_row_reg        <= '0;
            target_column_reg     <= '0;
            target_row_reg        <= '0;
            column_target_sum_reg <= '0;
            column_base_sum_reg   <= '0;
            row_target_sum_reg    <= '0;
            row_base_sum_reg      <= '0;
        end
        else
        begin
            source_column_reg     <= source_column_next;
            source_row_reg        <= source_row_next;
            target_column_reg     <= target_column_next;
            target_row_reg        <= target_row_next;
            column_target_sum_reg <= column_target_sum_next;
            column_base_sum_reg   <= column_base_sum_next;
            row_target_sum_reg    <= row_target_sum_next;
            row_base_sum_reg      <= row_base_sum_next;
        end
    end

`ifndef SYNTHESIS
    // Source column always lies inside the largest frame.
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(source_column_reg) < 32'(MAX_DIMENSION))
        else $error("source column beyond maximum dimension");

    // A frame start always produces a pick for the first target pixel.
    a_start_picks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && frame_start |-> emit)
        else $error("first pixel of a frame was not picked");
`endif

endmodule

`default_nettype wire

// File: rtl/core/nearest_neighbor_luma_downscaler.sv
// ============================================================================
// nearest_neighbor_luma_downscaler
// Nearest-neighbor downscaler for the luma plane of a raster-ordered stream.
// ============================================================================
// The block takes one luma byte per item and passes on, as luma minus 128,
// only the pixels that are the nearest-neighbor picks for the target frame:
// source column floor(dx*source_width/target_width) and row
// floor(dy*source_height/target_height). It takes one item per clock cycle
// while the output is not stalled; an item goes through an input register
// and the combinational pick logic and leaves from the output register. The
// per-item position update (two add-and-compare accumulator pairs) is what
// sets the clock period. tlast marks the last sample of an output line and
// tuser the last sample of the output frame. A set frame-start flag on an
// input item restarts all counters; without it they wrap by themselves at
// the end of each source frame. Size registers are taken as 1 when zero and
// are clamped at MAX_DIMENSION, and are to be written only while the stream
// is idle.
`default_nettype none

module nearest_neighbor_luma_downscaler
#(
    parameter int MAX_DIMENSION = nnld_pkg::MAX_DIMENSION
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] luma
    input  wire logic                             s_tuser,  // [0] frame_start
    // Output stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,  // [7:0] sample
    output logic                                  m_tlast,  // line_end
    output logic                                  m_tuser,  // [0] frame_end
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [nnld_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [nnld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [nnld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    nnld_pkg::cfg_t     cfg;
    nnld_pkg::result_t  result;
    logic               emit;
    logic               advance;
    logic               fire;

    logic                          in_valid_reg, in_valid_next;
    logic [nnld_pkg::LUMA_W-1:0]   in_luma_reg;
    logic                          in_start_reg;
    logic                          out_valid_reg, out_valid_next;
    nnld_pkg::result_t             out_result_reg;

    // Register file.
    nnld_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The pick stage moves whenever the output register is free or drains.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Pick logic and position counters.
    nnld_sel #(.MAX_DIMENSION(MAX_DIMENSION)) u_sel
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .luma        (in_luma_reg),
        .frame_start (in_start_reg),
        .cfg         (cfg),
        .emit        (emit),
        .result      (result)
    );

    // Valid bits of the input and output registers.
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
        if (advance)
            out_valid_next = fire && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_luma_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (fire && emit)
            out_result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg.sample;
    assign m_tlast  = out_result_reg.line_end;
    assign m_tuser  = out_result_reg.frame_end;

`ifndef SYNTHESIS
    // The last sample of a frame also closes its line.
    a_frame_end_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without line end");

    // A held item is not dropped while the output stalls.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("input item lost during output stall");
`endif

endmodule

`default_nettype wire
